### rtl/fssd_pkg.sv
// ----------------------------------------------------------------------------
// fssd_pkg
// Shared types, constants and helper functions for the filament slip and
// stall detector.
// ----------------------------------------------------------------------------
package fssd_pkg;

   // Fixed point position of the length accumulators.
   localparam int LENGTH_FRAC_BITS = 16;

   // Shared arithmetic unit geometry.
   localparam int ALU_W = 80;
   localparam int CNT_W = 7;

   // pi in Q30 and the shift that brings n*d*pi down to the length format.
   localparam logic [31:0] PI_Q = 32'hC90FDAA2;
   localparam int PI_SHIFT = 38 - LENGTH_FRAC_BITS;
   localparam int ARC_VW = 39 + LENGTH_FRAC_BITS;

   // Layer dividend width: 32-bit pulse total times 12-bit filament diameter.
   localparam int LAYER_DW = 44;

   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
   localparam logic [47:0] SLIP_MIN_LEN = 48'(100) << LENGTH_FRAC_BITS;
   localparam logic [13:0] SLIP_SCALE = 14'd10000;

   // Configuration port.
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CORE_DIAM   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIL_DIAM    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPOOL_WIDTH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPOOL_MAG   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLER_MAG   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLER_DIAM  = 3'd7;

   // Transaction kinds.
   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_SPOOL = 2'd1;
   localparam logic [1:0] KIND_IDLER = 2'd2;
   localparam logic [1:0] KIND_CHECK = 2'd3;

   // Status codes.
   localparam logic [1:0] STATUS_NONE  = 2'd0;
   localparam logic [1:0] STATUS_SLIP  = 2'd1;
   localparam logic [1:0] STATUS_STALL = 2'd2;
   localparam logic [1:0] STATUS_BREAK = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] pulse_count;
      logic [15:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] layer;
   } rsp_type;

   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic             start;
      alu_op_type       op;
      logic [ALU_W-1:0] opa;
      logic [ALU_W-1:0] opb;
      logic [CNT_W-1:0] count;
   } alu_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LAYER_PF,
      ST_LAYER_MW,
      ST_LAYER_DIV,
      ST_DIAM,
      ST_ARC_ND,
      ST_ARC_PI,
      ST_ARC_DIV,
      ST_EVAL,
      ST_SLIP_D,
      ST_SLIP_T,
      ST_RESULT
   } state_type;

   // Saturating add into a 48-bit length.
   function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [63:0] inc);
      logic [64:0] sum;
      sum = 65'(a) + 65'(inc);
      return (sum > 65'(MAX48)) ? MAX48 : sum[47:0];
   endfunction

   // Saturating add into a 32-bit counter.
   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] inc);
      logic [32:0] sum;
      sum = 33'(a) + 33'(inc);
      return sum[32] ? MAX32 : sum[31:0];
   endfunction

endpackage

### rtl/filament_slip_stall_detector.sv
// ----------------------------------------------------------------------------
// filament_slip_stall_detector
// Compares the wound length expected from the spool with the length measured
// by the idler wheel and reports slip, stall or break on check transactions.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time and holds req_stall high while
// it works. Every multiply and divide runs on one shared bit-serial unit, so
// the cost is one cycle per multiplier or quotient bit plus the issue of each
// operation. A clear transaction or one with zero pulses is done in the idle
// state. An idler transaction multiplies pulses by wheel diameter and pi and
// divides by the magnet count. A spool transaction first finds the layer and,
// when the layer changes, the new diameter, then runs the same steps. A check
// is judged from the timers, or after two multiplies when the theoretical
// length is over 100 mm, and then holds its result until it is taken.
// ----------------------------------------------------------------------------
module filament_slip_stall_detector import fssd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Configuration registers.
   logic [13:0] tol_ff;
   logic [19:0] timeout_ff;
   logic [15:0] core_ff;
   logic [11:0] fil_ff;
   logic [15:0] width_ff;
   logic [7:0]  smag_ff;
   logic [7:0]  imag_ff;
   logic [15:0] idw_ff;

   // Tracking state.
   logic [47:0] meas_ff, meas_in;
   logic [47:0] theo_ff, theo_in;
   logic [31:0] diam_ff, diam_in;
   logic [31:0] ptotal_ff, ptotal_in;
   logic [15:0] layer_ff, layer_in;
   logic [31:0] sidle_ff, sidle_in;
   logic [31:0] iidle_ff, iidle_in;

   // Sequencer.
   state_type   state_ff, state_in;
   logic        issued_ff, issued_in;
   logic        is_idler_ff, is_idler_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] pulses_ff, pulses_in;
   logic [ALU_W-1:0] s0_ff, s0_in;
   logic [23:0] s1_ff, s1_in;

   alu_req_type      alu_req;
   logic             alu_done;
   logic [ALU_W-1:0] alu_result;

   logic [7:0]  smag_eff, imag_eff;
   logic [31:0] p_sat;
   logic [15:0] q_sat;
   logic [47:0] len_diff;
   logic [1:0]  timer_status;
   logic [31:0] timeout_ext;

   fssd_alu u_alu (
      .clock      (clock),
      .reset      (reset),
      .alu_req    (alu_req),
      .alu_done   (alu_done),
      .alu_result (alu_result)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff     <= 14'd500;
         timeout_ff <= 20'd5000;
         core_ff    <= 16'd12800;
         fil_ff     <= 12'd448;
         width_ff   <= 16'd16384;
         smag_ff    <= 8'd1;
         imag_ff    <= 8'd1;
         idw_ff     <= 16'd5120;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TOLERANCE:   tol_ff     <= csr_data[13:0];
            CSR_TIMEOUT:     timeout_ff <= csr_data[19:0];
            CSR_CORE_DIAM:   core_ff    <= csr_data[15:0];
            CSR_FIL_DIAM:    fil_ff     <= csr_data[11:0];
            CSR_SPOOL_WIDTH: width_ff   <= csr_data[15:0];
            CSR_SPOOL_MAG:   smag_ff    <= csr_data[7:0];
            CSR_IDLER_MAG:   imag_ff    <= csr_data[7:0];
            CSR_IDLER_DIAM:  idw_ff     <= csr_data[15:0];
         endcase
      end
   end

   // A magnet count of zero counts as one.
   assign smag_eff = (smag_ff == 8'd0) ? 8'd1 : smag_ff;
   assign imag_eff = (imag_ff == 8'd0) ? 8'd1 : imag_ff;

   assign p_sat    = sat_add32(ptotal_ff, 32'(req_payload.pulse_count));
   assign q_sat    = (|alu_result[ALU_W-1:16]) ? 16'hFFFF : alu_result[15:0];
   assign len_diff = (theo_ff > meas_ff) ? theo_ff - meas_ff : meas_ff - theo_ff;

   // Stall and break decisions from the idle timers.
   assign timeout_ext = 32'(timeout_ff);
   always_comb begin
      if (iidle_ff > timeout_ext && sidle_ff < timeout_ext) begin
         timer_status = STATUS_STALL;
      end else if (sidle_ff > timeout_ext && iidle_ff < timeout_ext) begin
         timer_status = STATUS_BREAK;
      end else begin
         timer_status = STATUS_NONE;
      end
   end

   // Sequencer: next state, operand selection and state updates.
   always_comb begin
      state_in    = state_ff;
      issued_in   = issued_ff;
      is_idler_in = is_idler_ff;
      status_in   = status_ff;
      pulses_in   = pulses_ff;
      s0_in       = s0_ff;
      s1_in       = s1_ff;
      meas_in     = meas_ff;
      theo_in     = theo_ff;
      diam_in     = diam_ff;
      ptotal_in   = ptotal_ff;
      layer_in    = layer_ff;
      sidle_in    = sidle_ff;
      iidle_in    = iidle_ff;
      alu_req     = '0;
      req_stall   = (state_ff != ST_IDLE);
      rsp_valid   = (state_ff == ST_RESULT);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_payload.kind)
                  KIND_CLEAR: begin
                     meas_in   = '0;
                     theo_in   = '0;
                     diam_in   = 32'(core_ff);
                     ptotal_in = '0;
                     layer_in  = '0;
                     sidle_in  = '0;
                     iidle_in  = '0;
                  end
                  KIND_SPOOL: begin
                     if (req_payload.pulse_count != 16'd0) begin
                        sidle_in    = '0;
                        ptotal_in   = p_sat;
                        pulses_in   = req_payload.pulse_count;
                        is_idler_in = 1'b0;
                        if (fil_ff == 12'd0) begin
                           // No filament diameter: the layer is taken as zero.
                           if (layer_ff != 16'd0) begin
                              layer_in = '0;
                              diam_in  = 32'(core_ff);
                           end
                           state_in = ST_ARC_ND;
                        end else if (width_ff >= 16'(fil_ff)) begin
                           state_in = ST_LAYER_PF;
                        end else begin
                           s0_in    = ALU_W'(p_sat);
                           s1_in    = 24'(smag_eff);
                           state_in = ST_LAYER_DIV;
                        end
                     end
                  end
                  KIND_IDLER: begin
                     if (req_payload.pulse_count != 16'd0) begin
                        iidle_in    = '0;
                        pulses_in   = req_payload.pulse_count;
                        is_idler_in = 1'b1;
                        state_in    = ST_ARC_ND;
                     end
                  end
                  KIND_CHECK: begin
                     sidle_in = sat_add32(sidle_ff, 32'(req_payload.elapsed_ms));
                     iidle_in = sat_add32(iidle_ff, 32'(req_payload.elapsed_ms));
                     state_in = ST_EVAL;
                  end
               endcase
            end
         end

         // Pulse total times filament diameter.
         ST_LAYER_PF: begin
            alu_req.op    = ALU_MUL;
            alu_req.opa   = ALU_W'(ptotal_ff);
            alu_req.opb   = ALU_W'(fil_ff);
            alu_req.count = CNT_W'(12);
            if (!issued_ff) begin
               alu_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (alu_done) begin
               s0_in     = alu_result;
               issued_in = 1'b0;
               state_in  = ST_LAYER_MW;
            end
         end

         // Magnet count times spool width.
         ST_LAYER_MW: begin
            alu_req.op    = ALU_MUL;
            alu_req.opa   = ALU_W'(width_ff);
            alu_req.opb   = ALU_W'(smag_eff);
            alu_req.count = CNT_W'(8);
            if (!issued_ff) begin
               alu_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (alu_done) begin
               s1_in     = alu_result[23:0];
               issued_in = 1'b0;
               state_in  = ST_LAYER_DIV;
            end
         end

         // Layer quotient; a new layer moves the effective diameter.
         ST_LAYER_DIV: begin
            alu_req.op    = ALU_DIV;
            alu_req.opa   = ALU_W'(s1_ff);
            alu_req.opb   = {s0_ff[LAYER_DW-1:0], (ALU_W-LAYER_DW)'(0)};
            alu_req.count = CNT_W'(LAYER_DW);
            if (!issued_ff) begin
               alu_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (alu_done) begin
               issued_in = 1'b0;
               if (q_sat != layer_ff) begin
                  layer_in = q_sat;
                  state_in = ST_DIAM;
               end else begin
                  state_in = ST_ARC_ND;
               end
            end
         end

         // Diameter is core plus two filament diameters per layer.
         ST_DIAM: begin
            alu_req.op    = ALU_MUL;
            alu_req.opa   = ALU_W'(layer_ff);
            alu_req.opb   = ALU_W'(fil_ff);
            alu_req.count = CNT_W'(12);
            if (!issued_ff) begin
               alu_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (alu_done) begin
               diam_in   = 32'(core_ff) + {alu_result[30:0], 1'b0};
               issued_in = 1'b0;
               state_in  = ST_ARC_ND;
            end
         end

         // Pulses times wheel or spool diameter.
         ST_ARC_ND: begin
            alu_req.op    = ALU_MUL;
            alu_req.opa   = is_idler_ff ? ALU_W'(idw_ff) : ALU_W'(diam_ff);
            alu_req.opb   = ALU_W'(pulses_ff);
            alu_req.count = CNT_W'(16);
            if (!issued_ff) begin
               alu_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (alu_done) begin
               s0_in     = alu_result;
               issued_in = 1'b0;
               state_in  = ST_ARC_PI;
            end
         end

         // Times pi, scaled down to the length format.
         ST_ARC_PI: begin
            alu_req.op    = ALU_MUL;
            alu_req.opa   = s0_ff;
            alu_req.opb   = ALU_W'(PI_Q);
            alu_req.count = CNT_W'(32);
            if (!issued_ff) begin
               alu_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (alu_done) begin
               s0_in     = ALU_W'(alu_result[PI_SHIFT +: ARC_VW]);
               issued_in = 1'b0;
               state_in  = ST_ARC_DIV;
            end
         end

         // Divide by the magnet count and accumulate the length.
         ST_ARC_DIV: begin
            alu_req.op    = ALU_DIV;
            alu_req.opa   = is_idler_ff ? ALU_W'(imag_eff) : ALU_W'(smag_eff);
            alu_req.opb   = {s0_ff[ARC_VW-1:0], (ALU_W-ARC_VW)'(0)};
            alu_req.count = CNT_W'(ARC_VW);
            if (!issued_ff) begin
               alu_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (alu_done) begin
               if (is_idler_ff) begin
                  meas_in = sat_add48(meas_ff, alu_result[63:0]);
               end else begin
                  theo_in = sat_add48(theo_ff, alu_result[63:0]);
               end
               issued_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end

         // Slip is only judged past the minimum length.
         ST_EVAL: begin
            if (theo_ff > SLIP_MIN_LEN) begin
               state_in = ST_SLIP_D;
            end else begin
               status_in = timer_status;
               state_in  = ST_RESULT;
            end
         end

         // Length deviation scaled to hundredths of a percent.
         ST_SLIP_D: begin
            alu_req.op    = ALU_MUL;
            alu_req.opa   = ALU_W'(len_diff);
            alu_req.opb   = ALU_W'(SLIP_SCALE);
            alu_req.count = CNT_W'(14);
            if (!issued_ff) begin
               alu_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (alu_done) begin
               s0_in     = alu_result;
               issued_in = 1'b0;
               state_in  = ST_SLIP_T;
            end
         end

         // Tolerance times theoretical length, then the comparison.
         ST_SLIP_T: begin
            alu_req.op    = ALU_MUL;
            alu_req.opa   = ALU_W'(theo_ff);
            alu_req.opb   = ALU_W'(tol_ff);
            alu_req.count = CNT_W'(14);
            if (!issued_ff) begin
               alu_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (alu_done) begin
               status_in = (s0_ff > alu_result) ? STATUS_SLIP : timer_status;
               issued_in = 1'b0;
               state_in  = ST_RESULT;
            end
         end

         // Hold the result transaction until it is taken.
         ST_RESULT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         issued_ff   <= 1'b0;
         is_idler_ff <= 1'b0;
         status_ff   <= STATUS_NONE;
         meas_ff     <= '0;
         theo_ff     <= '0;
         diam_ff     <= 32'd12800;
         ptotal_ff   <= '0;
         layer_ff    <= '0;
         sidle_ff    <= '0;
         iidle_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         issued_ff   <= issued_in;
         is_idler_ff <= is_idler_in;
         status_ff   <= status_in;
         meas_ff     <= meas_in;
         theo_ff     <= theo_in;
         diam_ff     <= diam_in;
         ptotal_ff   <= ptotal_in;
         layer_ff    <= layer_in;
         sidle_ff    <= sidle_in;
         iidle_ff    <= iidle_in;
      end
   end

   always_ff @(posedge clock) begin
      pulses_ff <= pulses_in;
      s0_ff     <= s0_in;
      s1_ff     <= s1_in;
   end

   assign rsp_payload.status = status_ff;
   assign rsp_payload.layer  = layer_ff;

endmodule

### rtl/fssd_alu.sv
// ----------------------------------------------------------------------------
// fssd_alu
// Shared bit-serial multiply and restoring divide unit. One 80-bit adder is
// reused every cycle; a multiply takes one cycle per multiplier bit and a
// divide one cycle per quotient bit.
// ----------------------------------------------------------------------------
module fssd_alu import fssd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  alu_req_type      alu_req,
   output logic             alu_done,
   output logic [ALU_W-1:0] alu_result
);

   logic [ALU_W-1:0] acc_ff, acc_in;
   logic [ALU_W-1:0] a_ff, a_in;
   logic [ALU_W-1:0] b_ff, b_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   alu_op_type       op_ff, op_in;

   logic [ALU_W-1:0] add_x, add_y;
   logic             add_cin;
   logic [ALU_W:0]   add_sum;

   // The one adder: accumulate for multiply, trial subtract for divide.
   always_comb begin
      if (op_ff == ALU_DIV) begin
         add_x   = {acc_ff[ALU_W-2:0], b_ff[ALU_W-1]};
         add_y   = ~a_ff;
         add_cin = 1'b1;
      end else begin
         add_x   = acc_ff;
         add_y   = a_ff;
         add_cin = 1'b0;
      end
      add_sum = {1'b0, add_x} + {1'b0, add_y} + (ALU_W+1)'(add_cin);
   end

   // Iteration control.
   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      op_in   = op_ff;
      done_in = 1'b0;
      if (alu_req.start) begin
         acc_in  = '0;
         a_in    = alu_req.opa;
         b_in    = alu_req.opb;
         cnt_in  = alu_req.count;
         op_in   = alu_req.op;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (op_ff == ALU_DIV) begin
            // A carry out means the trial subtraction did not borrow.
            acc_in = add_sum[ALU_W] ? add_sum[ALU_W-1:0] : add_x;
            b_in   = {b_ff[ALU_W-2:0], add_sum[ALU_W]};
         end else begin
            if (b_ff[0]) begin
               acc_in = add_sum[ALU_W-1:0];
            end
            a_in = {a_ff[ALU_W-2:0], 1'b0};
            b_in = {1'b0, b_ff[ALU_W-1:1]};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= ALU_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   // The quotient collects in the low bits of the dividend register.
   assign alu_done   = done_ff;
   assign alu_result = (op_ff == ALU_DIV) ? b_ff : acc_ff;

endmodule

### rtl/fssd_checker.sv
// ----------------------------------------------------------------------------
// fssd_checker
// Port-level assertions for the filament slip and stall detector, bound to
// the top level.
// ----------------------------------------------------------------------------
module fssd_checker import fssd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input req_type               req_payload,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_type               rsp_payload,
   input logic                  csr_wr_en,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_data
);

   // No result is pending right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A pending result keeps the input side closed.
   a_busy_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result is pending");

   // Transactions other than checks never produce a result.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_payload.kind != KIND_CHECK) |=> !rsp_valid)
      else $error("result after a non-check transaction");

   // A check keeps the block busy in the following cycle.
   a_check_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_payload.kind == KIND_CHECK)
         |=> (req_stall && !rsp_valid))
      else $error("check transaction did not occupy the block");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

   logic unused_cfg;
   assign unused_cfg = csr_wr_en ^ (^csr_index) ^ (^csr_data);

endmodule

bind filament_slip_stall_detector fssd_checker u_fssd_checker (.*);
